@@ rtl/rth_pkg.sv @@
// Shared constants, types and register indexes for the ray/triangle grid block.
package rth_pkg;

  // Coordinate format: signed Q(CW-FB).FB
  localparam int CW = 20;
  localparam int FB = 10;

  // Derived arithmetic widths
  localparam int DW = CW + 1;               // edge and offset vectors
  localparam int HW = CW + DW + 1 - FB;     // D x E2 after the floor shift
  localparam int QW = 2 * DW + 1 - FB;      // S x E1 after the floor shift
  localparam int PW = DW + QW;              // widest dot product term
  localparam int SW = PW + 2;               // dot product sums
  localparam int RW = SW;                   // divider remainder, unsigned
  localparam int UW = FB + 1;               // u, v fractions, 0 .. 2^FB
  localparam int FW = FB + 2;               // fraction plus offset
  localparam int GW = 10;                   // grid size registers
  localparam int CLW = 11;                  // cell outputs

  localparam int OFFSET_INT = (2 * (1 << FB) + 50) / 100;
  localparam logic [FW-1:0] ONE_Q = FW'(1 << FB);
  localparam logic [FW-1:0] OFFSET_Q = FW'(OFFSET_INT);
  localparam logic [SW-1:0] ONE_DET = SW'(1 << FB);

  // Stream widths
  localparam int IN_FIELDS_W = 5 * 3 * CW + 1;
  localparam int IN_W = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 1 + 4 * CLW;
  localparam int OUT_W = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int VEC_W = 3 * CW;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [GW-1:0] GRID_RESET = GW'(100);

  // Front end to divider
  typedef struct packed {
    logic          miss;
    logic          mirror;
    logic [RW-1:0] nu;
    logic [RW-1:0] nv;
    logic [RW-1:0] det;
  } front_out_t;

  // Divider to scaler
  typedef struct packed {
    logic          miss;
    logic          mirror;
    logic [UW-1:0] uq;
    logic [UW-1:0] vq;
  } div_out_t;

  // Result word
  typedef struct packed {
    logic [CLW-1:0] cell_y_end;
    logic [CLW-1:0] cell_x_end;
    logic [CLW-1:0] cell_y_start;
    logic [CLW-1:0] cell_x_start;
    logic           hit;
  } result_t;

endpackage

@@ rtl/rth_front.sv @@
// Geometry pipeline: edges, cross products, dot products and hit tests.
module rth_front import rth_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [IN_W-1:0] in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output front_out_t      out_data
);

  localparam int CP = CW + DW;   // D*E2 product
  localparam int QP = 2 * DW;    // S*E1 product

  logic [7:1] v_r;
  logic [8:1] rdy;

  // stage 1
  logic signed [DW-1:0] e1_1_r [0:2], e2_1_r [0:2], s_1_r [0:2];
  logic signed [CW-1:0] d_1_r [0:2];
  logic                 m_1_r;
  // stage 2
  logic signed [CP-1:0] hp_r [0:5];
  logic signed [QP-1:0] qp_r [0:5];
  logic signed [DW-1:0] e1_2_r [0:2], e2_2_r [0:2], s_2_r [0:2];
  logic signed [CW-1:0] d_2_r [0:2];
  logic                 m_2_r;
  // stage 3
  logic signed [HW-1:0] h_r [0:2];
  logic signed [QW-1:0] q_r [0:2];
  logic signed [DW-1:0] e1_3_r [0:2], e2_3_r [0:2], s_3_r [0:2];
  logic signed [CW-1:0] d_3_r [0:2];
  logic                 m_3_r;
  // stage 4
  logic signed [PW-1:0] pdet_r [0:2], pnu_r [0:2], pnv_r [0:2], pnt_r [0:2];
  logic                 m_4_r;
  // stage 5
  logic signed [SW-1:0] det_r, nu_r, nv_r, nt_r;
  logic                 m_5_r;
  // stage 6
  logic signed [SW-1:0] det6_r, nu6_r, nv6_r, nt6_r;
  logic                 m_6_r;
  // stage 7
  front_out_t           o_r;

  logic signed [CW-1:0] org [0:2], dir [0:2], va [0:2], vb [0:2], vc [0:2];
  logic signed [CP:0]   hdiff [0:2];
  logic signed [QP:0]   qdiff [0:2];
  logic signed [SW-1:0] det_nxt, nu_nxt, nv_nxt, nt_nxt;
  logic signed [SW-1:0] usum;
  logic                 miss_nxt;

  // ready ripples back through bubbles
  always_comb begin
    rdy[8] = out_ready;
    for (int k = 7; k >= 1; k--) rdy[k] = !v_r[k] || rdy[k+1];
  end
  assign in_ready  = rdy[1];
  assign out_valid = v_r[7];
  assign out_data  = o_r;

  // unpack the five vectors
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      org[k] = signed'(in_data[0*VEC_W + k*CW +: CW]);
      dir[k] = signed'(in_data[1*VEC_W + k*CW +: CW]);
      va[k]  = signed'(in_data[2*VEC_W + k*CW +: CW]);
      vb[k]  = signed'(in_data[3*VEC_W + k*CW +: CW]);
      vc[k]  = signed'(in_data[4*VEC_W + k*CW +: CW]);
    end
  end

  // cross product differences, floor shift
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      hdiff[k] = (CP+1)'(hp_r[2*k]) - (CP+1)'(hp_r[2*k+1]);
      qdiff[k] = (QP+1)'(qp_r[2*k]) - (QP+1)'(qp_r[2*k+1]);
    end
  end

  // sign fold inputs and hit tests
  always_comb begin
    det_nxt = det_r;
    nu_nxt  = nu_r;
    nv_nxt  = nv_r;
    nt_nxt  = nt_r;
    if (det_r < 0) begin
      det_nxt = -det_r;
      nu_nxt  = -nu_r;
      nv_nxt  = -nv_r;
      nt_nxt  = -nt_r;
    end
    usum = nu6_r + nv6_r;
    miss_nxt = (det6_r < signed'(ONE_DET)) || (nu6_r < 0) || (nu6_r > det6_r) ||
               (nv6_r < 0) || (usum > det6_r) || (nt6_r <= 0);
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[1]) v_r[1] <= in_valid;
      for (int k = 2; k <= 7; k++) begin
        if (rdy[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      for (int k = 0; k < 3; k++) begin
        e1_1_r[k] <= DW'(vb[k]) - DW'(va[k]);
        e2_1_r[k] <= DW'(vc[k]) - DW'(va[k]);
        s_1_r[k]  <= DW'(org[k]) - DW'(va[k]);
        d_1_r[k]  <= dir[k];
      end
      m_1_r <= in_data[5*VEC_W];
    end
    if (rdy[2]) begin
      hp_r[0] <= CP'(d_1_r[1]) * CP'(e2_1_r[2]);
      hp_r[1] <= CP'(d_1_r[2]) * CP'(e2_1_r[1]);
      hp_r[2] <= CP'(d_1_r[2]) * CP'(e2_1_r[0]);
      hp_r[3] <= CP'(d_1_r[0]) * CP'(e2_1_r[2]);
      hp_r[4] <= CP'(d_1_r[0]) * CP'(e2_1_r[1]);
      hp_r[5] <= CP'(d_1_r[1]) * CP'(e2_1_r[0]);
      qp_r[0] <= QP'(s_1_r[1]) * QP'(e1_1_r[2]);
      qp_r[1] <= QP'(s_1_r[2]) * QP'(e1_1_r[1]);
      qp_r[2] <= QP'(s_1_r[2]) * QP'(e1_1_r[0]);
      qp_r[3] <= QP'(s_1_r[0]) * QP'(e1_1_r[2]);
      qp_r[4] <= QP'(s_1_r[0]) * QP'(e1_1_r[1]);
      qp_r[5] <= QP'(s_1_r[1]) * QP'(e1_1_r[0]);
      e1_2_r <= e1_1_r;
      e2_2_r <= e2_1_r;
      s_2_r  <= s_1_r;
      d_2_r  <= d_1_r;
      m_2_r  <= m_1_r;
    end
    if (rdy[3]) begin
      for (int k = 0; k < 3; k++) begin
        h_r[k] <= HW'(hdiff[k] >>> FB);
        q_r[k] <= QW'(qdiff[k] >>> FB);
      end
      e1_3_r <= e1_2_r;
      e2_3_r <= e2_2_r;
      s_3_r  <= s_2_r;
      d_3_r  <= d_2_r;
      m_3_r  <= m_2_r;
    end
    if (rdy[4]) begin
      for (int k = 0; k < 3; k++) begin
        pdet_r[k] <= PW'(e1_3_r[k]) * PW'(h_r[k]);
        pnu_r[k]  <= PW'(s_3_r[k]) * PW'(h_r[k]);
        pnv_r[k]  <= PW'(d_3_r[k]) * PW'(q_r[k]);
        pnt_r[k]  <= PW'(e2_3_r[k]) * PW'(q_r[k]);
      end
      m_4_r <= m_3_r;
    end
    if (rdy[5]) begin
      det_r <= SW'(pdet_r[0]) + SW'(pdet_r[1]) + SW'(pdet_r[2]);
      nu_r  <= SW'(pnu_r[0]) + SW'(pnu_r[1]) + SW'(pnu_r[2]);
      nv_r  <= SW'(pnv_r[0]) + SW'(pnv_r[1]) + SW'(pnv_r[2]);
      nt_r  <= SW'(pnt_r[0]) + SW'(pnt_r[1]) + SW'(pnt_r[2]);
      m_5_r <= m_4_r;
    end
    if (rdy[6]) begin
      det6_r <= det_nxt;
      nu6_r  <= nu_nxt;
      nv6_r  <= nv_nxt;
      nt6_r  <= nt_nxt;
      m_6_r  <= m_5_r;
    end
    if (rdy[7]) begin
      o_r.miss   <= miss_nxt;
      o_r.mirror <= m_6_r;
      o_r.nu     <= RW'(nu6_r);
      o_r.nv     <= RW'(nv6_r);
      o_r.det    <= RW'(det6_r);
    end
  end

endmodule

@@ rtl/rth_div.sv @@
// Restoring fraction divider: one quotient bit per stage for u and v.
module rth_div import rth_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  front_out_t in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output div_out_t   out_data
);

  localparam int NS = FB + 1;

  logic [NS-1:0] v_r;
  logic [NS:0]   rdy;
  logic [RW-1:0] ru_r [0:NS-1], rv_r [0:NS-1], den_r [0:NS-1];
  logic [UW-1:0] qu_r [0:NS-1], qv_r [0:NS-1];
  logic          miss_r [0:NS-1], mir_r [0:NS-1];

  // ready ripples back through bubbles
  always_comb begin
    rdy[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) rdy[k] = !v_r[k] || rdy[k+1];
  end
  assign in_ready  = rdy[0];
  assign out_valid = v_r[NS-1];
  assign out_data  = '{miss: miss_r[NS-1], mirror: mir_r[NS-1],
                       uq: qu_r[NS-1], vq: qv_r[NS-1]};

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  for (genvar j = 0; j < NS; j++) begin : g_step
    logic [RW-1:0] rem_u, rem_v, den;
    logic [UW-1:0] qin_u, qin_v;
    logic          bit_u, bit_v, miss_in, mir_in;

    // pick the partial remainder this step works on
    if (j == 0) begin : g_first
      assign rem_u   = in_data.nu;
      assign rem_v   = in_data.nv;
      assign den     = in_data.det;
      assign qin_u   = '0;
      assign qin_v   = '0;
      assign miss_in = in_data.miss;
      assign mir_in  = in_data.mirror;
    end else begin : g_next
      assign rem_u   = {ru_r[j-1][RW-2:0], 1'b0};
      assign rem_v   = {rv_r[j-1][RW-2:0], 1'b0};
      assign den     = den_r[j-1];
      assign qin_u   = qu_r[j-1];
      assign qin_v   = qv_r[j-1];
      assign miss_in = miss_r[j-1];
      assign mir_in  = mir_r[j-1];
    end

    assign bit_u = rem_u >= den;
    assign bit_v = rem_v >= den;

    // subtract where it fits, shift in the quotient bit
    always_ff @(posedge clk) begin
      if (rdy[j]) begin
        ru_r[j]   <= bit_u ? rem_u - den : rem_u;
        rv_r[j]   <= bit_v ? rem_v - den : rem_v;
        qu_r[j]   <= {qin_u[UW-2:0], bit_u};
        qv_r[j]   <= {qin_v[UW-2:0], bit_v};
        den_r[j]  <= den;
        miss_r[j] <= miss_in;
        mir_r[j]  <= mir_in;
      end
    end
  end

endmodule

@@ rtl/rth_scale.sv @@
// Mirror, offset and grid scaling of u and v into cell corners.
module rth_scale import rth_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  div_out_t      in_data,
  input  logic [GW-1:0] grid_width,
  input  logic [GW-1:0] grid_height,
  output logic          out_valid,
  input  logic          out_ready,
  output result_t       out_data
);

  localparam int MW = FW + GW;

  logic [1:0]    v_r;
  logic [2:0]    rdy;
  logic [MW-1:0] px0_r, py0_r, px1_r, py1_r;
  logic          miss_r;
  result_t       res_r;
  logic [FW-1:0] uf, vf;

  assign rdy[2] = out_ready;
  assign rdy[1] = !v_r[1] || rdy[2];
  assign rdy[0] = !v_r[0] || rdy[1];
  assign in_ready  = rdy[0];
  assign out_valid = v_r[1];
  assign out_data  = res_r;

  // optional mirror
  always_comb begin
    uf = FW'(in_data.uq);
    vf = FW'(in_data.vq);
    if (in_data.mirror) begin
      uf = ONE_Q - FW'(in_data.uq);
      vf = ONE_Q - FW'(in_data.vq);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      if (rdy[1]) v_r[1] <= v_r[0];
    end
  end

  // multiply, then truncate the fraction and zero a miss
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      px0_r  <= MW'(vf) * MW'(grid_width);
      py0_r  <= MW'(uf) * MW'(grid_height);
      px1_r  <= MW'(vf + OFFSET_Q) * MW'(grid_width);
      py1_r  <= MW'(uf + OFFSET_Q) * MW'(grid_height);
      miss_r <= in_data.miss;
    end
    if (rdy[1]) begin
      res_r.hit          <= !miss_r;
      res_r.cell_x_start <= miss_r ? '0 : px0_r[FB +: CLW];
      res_r.cell_y_start <= miss_r ? '0 : py0_r[FB +: CLW];
      res_r.cell_x_end   <= miss_r ? '0 : px1_r[FB +: CLW];
      res_r.cell_y_end   <= miss_r ? '0 : py1_r[FB +: CLW];
    end
  end

endmodule

@@ rtl/ray_triangle_hit_to_grid.sv @@
// Throughput: one word per cycle while out_tready is high; 7 geometry stages,
// 11 divider stages (one quotient bit each) and 2 scaling stages. A stall
// holds every stage that holds a word, while stages behind a bubble
// still advance, so bubbles are squeezed out.
// Reset (rst_n low, synchronous): pipeline empties, grid sizes return to 100.
module ray_triangle_hit_to_grid import rth_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // ray_origin, ray_direction, vertex_a, vertex_b, vertex_c (60 each), mirror_uv, pad
  input  logic [IN_W-1:0]      in_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // hit, cell_x_start, cell_y_start, cell_x_end, cell_y_end (11 each), pad
  output logic [OUT_W-1:0]     out_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GW-1:0]        cfg_data
);

  logic [GW-1:0] gw_r, gh_r;
  logic          f_valid, f_ready, d_valid, d_ready;
  front_out_t    f_data;
  div_out_t      d_data;
  result_t       res;

  // configuration writes
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r <= GRID_RESET;
      gh_r <= GRID_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GRID_WIDTH:  gw_r <= cfg_data;
        REG_GRID_HEIGHT: gh_r <= cfg_data;
        default: ;
      endcase
    end
  end

  rth_front u_front (
    .clk, .rst_n,
    .in_valid (in_tvalid), .in_ready (in_tready), .in_data (in_tdata),
    .out_valid (f_valid), .out_ready (f_ready), .out_data (f_data)
  );

  rth_div u_div (
    .clk, .rst_n,
    .in_valid (f_valid), .in_ready (f_ready), .in_data (f_data),
    .out_valid (d_valid), .out_ready (d_ready), .out_data (d_data)
  );

  rth_scale u_scale (
    .clk, .rst_n,
    .in_valid (d_valid), .in_ready (d_ready), .in_data (d_data),
    .grid_width (gw_r), .grid_height (gh_r),
    .out_valid (out_tvalid), .out_ready (out_tready), .out_data (res)
  );

  assign out_tdata = {{(OUT_W - OUT_FIELDS_W){1'b0}}, res};

endmodule

@@ rtl/rth_checker.sv @@
// Port-level checks for the ray/triangle grid block, bound to the top level.
module rth_checker import rth_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  result_t r;
  assign r = out_tdata[OUT_FIELDS_W-1:0];

  // hold a stalled result word
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // empty right after reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a miss carries no cells
  a_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !r.hit |-> r.cell_x_start == '0 && r.cell_y_start == '0 &&
                             r.cell_x_end == '0 && r.cell_y_end == '0)
    else $error("miss with nonzero cells");

  // rectangle corners are ordered
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && r.hit |-> r.cell_x_end >= r.cell_x_start &&
                            r.cell_y_end >= r.cell_y_start)
    else $error("cell end below start");

endmodule

bind ray_triangle_hit_to_grid rth_checker u_rth_checker (
  .clk, .rst_n, .out_tvalid, .out_tready, .out_tdata
);
